FILE: rtl/core/slbc_pkg.sv
`default_nettype none

package slbc_pkg;

   // Event codes carried in the operation field
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_SET_MODE = 2'd1;
   localparam logic [1:0] OP_BEGIN    = 2'd2;
   localparam logic [1:0] OP_END      = 2'd3;

   // Display modes
   localparam logic [3:0] MODE_OFF          = 4'd0;
   localparam logic [3:0] MODE_CONNECTING   = 4'd1;
   localparam logic [3:0] MODE_PAIRING      = 4'd2;
   localparam logic [3:0] MODE_HANDSHAKE    = 4'd3;
   localparam logic [3:0] MODE_CONNECTED    = 4'd4;
   localparam logic [3:0] MODE_DISCONNECTED = 4'd5;
   localparam logic [3:0] MODE_REJECT       = 4'd6;
   localparam logic [3:0] MODE_FORGET_OK    = 4'd7;
   localparam logic [3:0] MODE_ERROR        = 4'd8;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 1'd1;

   // Timing in milliseconds
   localparam logic [9:0]  BLINK_CONNECTING_MS = 10'd700;
   localparam logic [9:0]  BLINK_PAIRING_MS    = 10'd280;
   localparam logic [9:0]  BLINK_HANDSHAKE_MS  = 10'd180;
   localparam logic [31:0] FLASH_REJECT_MS     = 32'd180;
   localparam logic [31:0] FLASH_FORGET_MS     = 32'd220;
   localparam logic [6:0]  ERROR_HOLD_MS       = 7'd120;
   localparam logic [2:0]  ERROR_EXTRA_PAINTS  = 3'd5;

   // Brightness scaling: full = 255*pct/100, dim = 255*pct/500, both by reciprocal
   localparam logic [12:0] FULL_RECIP   = 13'd5243;   // ceil(2^19 / 100)
   localparam int unsigned FULL_SHIFT   = 19;
   localparam logic [15:0] DIM_RECIP    = 16'd33555;  // ceil(2^24 / 500)
   localparam int unsigned DIM_SHIFT    = 24;
   localparam logic [7:0]  DIM_FLOOR    = 8'd8;
   localparam logic [7:0]  RESET_PERCENT = 8'd100;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  mode;
      logic [31:0] now_ms;
      logic        screen_off;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] brightness;
      logic [6:0] hold_ms;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  cur_mode;
      logic [3:0]  after_mode;
      logic [31:0] deadline;
      logic        phase_on;
      logic [31:0] toggle_ms;
      logic        held;
   } state_type;

   // What one event produces
   typedef struct packed {
      logic    has_result;
      logic    error_seq;
      rsp_type first;
      rsp_type red_paint;
   } step_out_type;

   typedef struct packed {
      logic       allowed;
      logic [7:0] br_full;
      logic [7:0] br_dim;
   } light_type;

   function automatic rsp_type make_paint(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic dim,
                                          input light_type light,
                                          input logic [6:0] hold);
      rsp_type p;
      p.hold_ms = hold;
      p.last    = 1'b0;
      if (light.allowed) begin
         p.red        = r;
         p.green      = g;
         p.blue       = b;
         p.brightness = dim ? light.br_dim : light.br_full;
      end else begin
         p.red        = 8'd0;
         p.green      = 8'd0;
         p.blue       = 8'd0;
         p.brightness = 8'd0;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/status_led_blink_controller.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   slbc_pkg::req_type (event, mode, time, screen)
// rsp_      out        rsp_valid/rsp_stall   slbc_pkg::rsp_type (color, brightness, hold)
// csr_      in         csr_valid/csr_ready   csr_index selects register, csr_data value
//
// One event per cycle while req_stall is low: an event is held in the input register,
// is evaluated there and its first paint, if it has one, lands in the output register.
// An error event takes six output transfers, one paint each; an event waiting behind
// it stays in the input register, with req_stall high, while the last five drain.
// Reset (synchronous, active high) clears the mode state, empties both registers and sets LED enable and 100 percent.
// rsp_stall reaches req_stall in the same cycle; there is no skid buffer.
// A csr write lands in the percent register, and the rescaled brightness is registered from it.

module status_led_blink_controller (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  slbc_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output slbc_pkg::rsp_type                   rsp_item,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [slbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [slbc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import slbc_pkg::*;

   // Configuration
   logic        led_enable_ff, led_enable_in;
   logic [6:0]  percent_ff, percent_in;
   logic [7:0]  br_full_ff, br_full_in;
   logic [7:0]  br_dim_ff, br_dim_in;

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_item_ff, s1_item_in;

   // Mode state
   state_type   state_ff, state_in;

   // Output register and error sequence
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   rsp_type     red_paint_ff, red_paint_in;
   logic [2:0]  err_left_ff, err_left_in;

   logic         out_free;
   logic         fire;
   logic         rsp_xfer;
   light_type    light;
   state_type    step_state;
   step_out_type step_result;
   rsp_type      off_paint;

   logic [14:0] pct_x255;
   logic [27:0] full_prod;
   logic [30:0] dim_prod;
   logic [8:0]  full_q;
   logic [6:0]  dim_q;

   // Config port takes a write every cycle
   assign csr_ready = 1'b1;

   always_comb begin
      led_enable_in = led_enable_ff;
      percent_in    = percent_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LED_ENABLE: led_enable_in = csr_data[0];
            CSR_BRIGHTNESS: percent_in    = csr_data;
            default:        led_enable_in = led_enable_ff;
         endcase
      end
   end

   // Scale percent to brightness: 255*p/100 saturated, 255*p/500 floored at 8
   assign pct_x255  = {percent_ff, 8'd0} - {8'd0, percent_ff};
   assign full_prod = 28'(pct_x255) * 28'(FULL_RECIP);
   assign dim_prod  = 31'(pct_x255) * 31'(DIM_RECIP);
   assign full_q    = full_prod[FULL_SHIFT +: 9];
   assign dim_q     = dim_prod[DIM_SHIFT +: 7];
   assign br_full_in = (full_q > 9'd255) ? 8'd255 : full_q[7:0];
   assign br_dim_in  = ({1'b0, dim_q} < DIM_FLOOR) ? DIM_FLOOR : {1'b0, dim_q};

   assign light.allowed = led_enable_ff & (percent_ff != 7'd0);
   assign light.br_full = br_full_ff;
   assign light.br_dim  = br_dim_ff;

   // Advance an event only when the output register can take its first paint
   // and no error sequence is still draining.
   assign rsp_xfer  = rsp_valid_ff & ~rsp_stall;
   assign out_free  = ~rsp_valid_ff | (~rsp_stall & (err_left_ff == 3'd0));
   assign fire      = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_item_in  = req_item;
      end
   end

   slbc_step u_step (
      .item       (s1_item_ff),
      .state      (state_ff),
      .light_raw  (light),
      .next_state (step_state),
      .result     (step_result)
   );

   assign state_in = fire ? step_state : state_ff;

   // Off paint of the error sequence: the red paint with the red dropped,
   // so brightness and screen-off darkening follow the red paint
   always_comb begin
      off_paint     = red_paint_ff;
      off_paint.red = 8'd0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      red_paint_in = red_paint_ff;
      err_left_in  = err_left_ff;
      if (fire) begin
         // Load the first paint of the new event
         rsp_valid_in = step_result.has_result;
         rsp_in       = step_result.first;
         red_paint_in = step_result.red_paint;
         err_left_in  = step_result.error_seq ? ERROR_EXTRA_PAINTS : 3'd0;
      end else if (rsp_xfer && err_left_ff != 3'd0) begin
         // Step the error sequence: red and off alternate, off comes last
         rsp_in      = err_left_ff[0] ? off_paint : red_paint_ff;
         rsp_in.last = (err_left_ff == 3'd1);
         err_left_in = err_left_ff - 3'd1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_enable_ff <= 1'b1;
         percent_ff    <= RESET_PERCENT[6:0];
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         err_left_ff   <= 3'd0;
         state_ff      <= '{cur_mode: MODE_OFF, after_mode: MODE_CONNECTING,
                            deadline: 32'd0, phase_on: 1'b0, toggle_ms: 32'd0,
                            held: 1'b0};
      end else begin
         led_enable_ff <= led_enable_in;
         percent_ff    <= percent_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         err_left_ff   <= err_left_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      br_full_ff   <= br_full_in;
      br_dim_ff    <= br_dim_in;
      s1_item_ff   <= s1_item_in;
      rsp_ff       <= rsp_in;
      red_paint_ff <= red_paint_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/slbc_step.sv
`default_nettype none

module slbc_step (
   input  slbc_pkg::req_type      item,
   input  slbc_pkg::state_type    state,
   input  slbc_pkg::light_type    light_raw,
   output slbc_pkg::state_type    next_state,
   output slbc_pkg::step_out_type result
);
   import slbc_pkg::*;

   light_type   light;
   logic        run_tick;
   logic        is_blink;
   logic [9:0]  period;
   logic [31:0] elapsed;

   assign light.allowed = light_raw.allowed & ~item.screen_off;
   assign light.br_full = light_raw.br_full;
   assign light.br_dim  = light_raw.br_dim;

   always_comb begin
      next_state       = state;
      result           = '0;
      run_tick         = 1'b0;
      is_blink         = 1'b0;
      period           = BLINK_CONNECTING_MS;
      elapsed          = 32'd0;

      case (item.operation)
         OP_TICK: begin
            run_tick = 1'b1;
         end
         OP_BEGIN, OP_END: begin
            next_state.held     = (item.operation == OP_BEGIN);
            next_state.cur_mode = MODE_OFF;
            next_state.deadline = 32'd0;
            result.has_result   = 1'b1;
            result.first        = make_paint(8'd0, 8'd0, 8'd0, 1'b0, light, 7'd0);
            result.first.last   = 1'b1;
         end
         OP_SET_MODE: begin
            case (item.mode)
               MODE_REJECT: begin
                  next_state.after_mode = (state.cur_mode == MODE_PAIRING) ?
                                          MODE_PAIRING : MODE_CONNECTING;
                  next_state.cur_mode   = MODE_REJECT;
                  next_state.deadline   = item.now_ms + FLASH_REJECT_MS;
                  result.has_result     = 1'b1;
                  result.first          = make_paint(8'd255, 8'd0, 8'd0, 1'b0, light, 7'd0);
                  result.first.last     = 1'b1;
               end
               MODE_FORGET_OK: begin
                  next_state.after_mode = MODE_OFF;
                  next_state.cur_mode   = MODE_FORGET_OK;
                  next_state.deadline   = item.now_ms + FLASH_FORGET_MS;
                  result.has_result     = 1'b1;
                  result.first          = make_paint(8'd0, 8'd255, 8'd0, 1'b0, light, 7'd0);
                  result.first.last     = 1'b1;
               end
               MODE_ERROR: begin
                  next_state.cur_mode = MODE_OFF;
                  next_state.deadline = 32'd0;
                  result.has_result   = 1'b1;
                  result.error_seq    = 1'b1;
                  result.red_paint    = make_paint(8'd255, 8'd0, 8'd0, 1'b0, light,
                                                   ERROR_HOLD_MS);
                  result.first        = result.red_paint;
               end
               default: begin
                  next_state.cur_mode  = item.mode;
                  next_state.deadline  = 32'd0;
                  next_state.toggle_ms = item.now_ms;
                  next_state.phase_on  = 1'b1;
                  run_tick             = 1'b1;
               end
            endcase
         end
         default: begin
            run_tick = 1'b0;
         end
      endcase

      // Tick while held: if lit, expire a pending flash, advance the blink and paint the mode; else paint dark
      if (run_tick && next_state.held) begin
         result.has_result = 1'b1;
         if (!light.allowed) begin
            result.first = make_paint(8'd0, 8'd0, 8'd0, 1'b0, light, 7'd0);
         end else begin
            if (next_state.deadline != 32'd0 && item.now_ms >= next_state.deadline) begin
               next_state.deadline  = 32'd0;
               next_state.cur_mode  = next_state.after_mode;
               next_state.toggle_ms = item.now_ms;
               next_state.phase_on  = 1'b1;
            end
            case (next_state.cur_mode)
               MODE_CONNECTING: begin
                  is_blink = 1'b1;
                  period   = BLINK_CONNECTING_MS;
               end
               MODE_PAIRING: begin
                  is_blink = 1'b1;
                  period   = BLINK_PAIRING_MS;
               end
               MODE_HANDSHAKE: begin
                  is_blink = 1'b1;
                  period   = BLINK_HANDSHAKE_MS;
               end
               default: begin
                  is_blink = 1'b0;
               end
            endcase
            elapsed = item.now_ms - next_state.toggle_ms;
            if (is_blink && elapsed >= {22'd0, period}) begin
               next_state.toggle_ms = item.now_ms;
               next_state.phase_on  = ~next_state.phase_on;
            end
            case (next_state.cur_mode)
               MODE_CONNECTING, MODE_PAIRING: begin
                  result.first = make_paint(8'd0, 8'd0,
                                            next_state.phase_on ? 8'd255 : 8'd0,
                                            1'b0, light, 7'd0);
               end
               MODE_HANDSHAKE: begin
                  result.first = make_paint(8'd0,
                                            next_state.phase_on ? 8'd200 : 8'd0,
                                            next_state.phase_on ? 8'd255 : 8'd40,
                                            1'b0, light, 7'd0);
               end
               MODE_CONNECTED: begin
                  result.first = make_paint(8'd0, 8'd0, 8'd255, 1'b1, light, 7'd0);
               end
               MODE_DISCONNECTED, MODE_REJECT: begin
                  result.first = make_paint(8'd255, 8'd0, 8'd0, 1'b0, light, 7'd0);
               end
               MODE_FORGET_OK: begin
                  result.first = make_paint(8'd0, 8'd255, 8'd0, 1'b0, light, 7'd0);
               end
               default: begin
                  result.first = make_paint(8'd0, 8'd0, 8'd0, 1'b0, light, 7'd0);
               end
            endcase
         end
         result.first.last = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/slbc_checker.sv
`default_nettype none

module slbc_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input slbc_pkg::rsp_type rsp_item
);
   import slbc_pkg::*;

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // Nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only error paints carry a hold time, and it is always the same
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.hold_ms == 7'd0) || (rsp_item.hold_ms == ERROR_HOLD_MS))
      else $error("bad hold time");

   // Events other than error produce a single result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.hold_ms == 7'd0 |-> rsp_item.last)
      else $error("single paint without last");

   // A dark LED paints no color
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.brightness == 8'd0 |->
         rsp_item.red == 8'd0 && rsp_item.green == 8'd0 && rsp_item.blue == 8'd0)
      else $error("color with zero brightness");

endmodule

bind status_led_blink_controller slbc_checker u_slbc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: tb/status_led_blink_controller_tb.sv
module status_led_blink_controller_tb;
   import slbc_pkg::*;

   localparam int IDLE_PCT      = 27;    // chance in a hundred that a side idles
   localparam int SETTLE_CYCLES = 8;     // in-to-out latency plus margin
   localparam int WATCHDOG_MAX  = 5000;  // cycles with no transfer before giving up
   localparam int PHASE_EVENTS  = 58;    // result-producing events per register setting

   // Blink half-periods, flash lengths and error hold, in milliseconds
   localparam logic [31:0] HALF_CONNECTING = 32'd700;
   localparam logic [31:0] HALF_PAIRING    = 32'd280;
   localparam logic [31:0] HALF_HANDSHAKE  = 32'd180;
   localparam logic [31:0] REJECT_FLASH    = 32'd180;
   localparam logic [31:0] FORGET_FLASH    = 32'd220;
   localparam logic [6:0]  ERROR_HOLD      = 7'd120;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   status_led_blink_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // LED state predictor: own copy of the mode state and both registers
   // ---------------------------------------------------------------------
   logic        cfg_led_enable;
   logic [6:0]  cfg_percent;
   logic [3:0]  mdl_mode;
   logic [3:0]  mdl_after_flash;
   logic [31:0] mdl_deadline;
   logic        mdl_phase_on;
   logic [31:0] mdl_toggle_ms;
   logic        mdl_held;

   rsp_type     step_paints[$];     // paints caused by the event being predicted
   rsp_type     pending_paints[$];  // paints still owed by the block, oldest first

   bit          calm = 1'b0;        // suppress idling on both sides
   logic [31:0] ms_cursor = 32'd10000;
   int          last_event_paints;
   int          events_sent    = 0;
   int          events_painted = 0;
   int          paints_checked = 0;
   int          csr_writes     = 0;
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;

   function automatic bit led_lit(input logic so);
      return !so && cfg_percent != 7'd0 && cfg_led_enable;
   endfunction

   // Append one paint to those of the current event
   function automatic void add_paint(input rsp_type p);
      step_paints = {step_paints, p};
   endfunction

   // Build one paint: colour and brightness scaled from the percent register
   function automatic rsp_type paint_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input bit dim,
                                        input logic [6:0] hold, input logic so);
      rsp_type     p;
      int unsigned level;
      p.hold_ms = hold;
      p.last    = 1'b0;
      if (!led_lit(so)) begin
         p.red        = 8'd0;
         p.green      = 8'd0;
         p.blue       = 8'd0;
         p.brightness = 8'd0;
      end else begin
         level = 32'd255 * cfg_percent;
         level = level * (dim ? 32'd20 : 32'd100) / 32'd10000;
         if (level > 255) level = 255;
         if (dim && level < 8) level = 8;
         p.red        = r;
         p.green      = g;
         p.blue       = b;
         p.brightness = level[7:0];
      end
      return p;
   endfunction

   // Toggle the blink phase once the half-period has elapsed (wrapping difference)
   function automatic bit blink_phase(input logic [31:0] now, input logic [31:0] half);
      logic [31:0] since;
      since = now - mdl_toggle_ms;
      if (since >= half) begin
         mdl_toggle_ms = now;
         mdl_phase_on  = !mdl_phase_on;
      end
      return mdl_phase_on;
   endfunction

   function automatic void tick_paint(input logic [31:0] now, input logic so);
      bit on;
      if (!mdl_held) return;
      if (!led_lit(so)) begin
         // dark paint, state left alone
         add_paint(paint_of(8'd0, 8'd0, 8'd0, 1'b0, 7'd0, so));
         return;
      end
      // Plain unsigned compare: a deadline that wrapped past zero is due at once
      if (mdl_deadline != 32'd0 && now >= mdl_deadline) begin
         mdl_deadline  = 32'd0;
         mdl_mode      = mdl_after_flash;
         mdl_toggle_ms = now;
         mdl_phase_on  = 1'b1;
      end
      case (mdl_mode)
         MODE_CONNECTING: begin
            on = blink_phase(now, HALF_CONNECTING);
            add_paint(paint_of(8'd0, 8'd0, on ? 8'd255 : 8'd0, 1'b0, 7'd0, so));
         end
         MODE_PAIRING: begin
            on = blink_phase(now, HALF_PAIRING);
            add_paint(paint_of(8'd0, 8'd0, on ? 8'd255 : 8'd0, 1'b0, 7'd0, so));
         end
         MODE_HANDSHAKE: begin
            on = blink_phase(now, HALF_HANDSHAKE);
            add_paint(paint_of(8'd0, on ? 8'd200 : 8'd0, on ? 8'd255 : 8'd40,
                               1'b0, 7'd0, so));
         end
         MODE_CONNECTED:
            add_paint(paint_of(8'd0, 8'd0, 8'd255, 1'b1, 7'd0, so));
         MODE_DISCONNECTED, MODE_REJECT:
            add_paint(paint_of(8'd255, 8'd0, 8'd0, 1'b0, 7'd0, so));
         MODE_FORGET_OK:
            add_paint(paint_of(8'd0, 8'd255, 8'd0, 1'b0, 7'd0, so));
         default:
            add_paint(paint_of(8'd0, 8'd0, 8'd0, 1'b0, 7'd0, so));
      endcase
   endfunction

   // Advance the predictor by one accepted event; queue its paints, return their count
   function automatic int predict_event(input req_type ev);
      int n;
      step_paints.delete();
      case (ev.operation)
         OP_TICK:
            tick_paint(ev.now_ms, ev.screen_off);
         OP_BEGIN, OP_END: begin
            if (ev.operation == OP_BEGIN) mdl_held = 1'b1;
            mdl_mode     = MODE_OFF;
            mdl_deadline = 32'd0;
            add_paint(paint_of(8'd0, 8'd0, 8'd0, 1'b0, 7'd0, ev.screen_off));
            if (ev.operation == OP_END) mdl_held = 1'b0;
         end
         default: begin
            case (ev.mode)
               MODE_REJECT: begin
                  mdl_after_flash = (mdl_mode == MODE_PAIRING) ? MODE_PAIRING : MODE_CONNECTING;
                  mdl_mode        = MODE_REJECT;
                  mdl_deadline    = ev.now_ms + REJECT_FLASH;
                  add_paint(paint_of(8'd255, 8'd0, 8'd0, 1'b0, 7'd0, ev.screen_off));
               end
               MODE_FORGET_OK: begin
                  mdl_after_flash = MODE_OFF;
                  mdl_mode        = MODE_FORGET_OK;
                  mdl_deadline    = ev.now_ms + FORGET_FLASH;
                  add_paint(paint_of(8'd0, 8'd255, 8'd0, 1'b0, 7'd0, ev.screen_off));
               end
               MODE_ERROR: begin
                  for (int i = 0; i < 3; i++) begin
                     add_paint(paint_of(8'd255, 8'd0, 8'd0, 1'b0, ERROR_HOLD,
                                        ev.screen_off));
                     add_paint(paint_of(8'd0, 8'd0, 8'd0, 1'b0, ERROR_HOLD,
                                        ev.screen_off));
                  end
                  mdl_mode     = MODE_OFF;
                  mdl_deadline = 32'd0;
               end
               default: begin
                  // store the mode as given, restart the blink on, then tick
                  mdl_mode      = ev.mode;
                  mdl_deadline  = 32'd0;
                  mdl_toggle_ms = ev.now_ms;
                  mdl_phase_on  = 1'b1;
                  tick_paint(ev.now_ms, ev.screen_off);
               end
            endcase
         end
      endcase
      n = step_paints.size();
      if (n > 0) step_paints[n-1].last = 1'b1;
      pending_paints = {pending_paints, step_paints};
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      if (mismatch_count < 10) begin
         $write("%s: expected r=%0d g=%0d b=%0d br=%0d hold=%0d last=%0d,", what,
                want.red, want.green, want.blue, want.brightness, want.hold_ms, want.last);
         $display(" got r=%0d g=%0d b=%0d br=%0d hold=%0d last=%0d", got.red, got.green,
                  got.blue, got.brightness, got.hold_ms, got.last);
      end
      mismatch_count++;
   endtask

   // Compare every accepted paint against the oldest one owed
   always @(posedge clock) begin : check_paints
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_paints.size() == 0) begin
            report_mismatch("paint with nothing owed", '0, rsp_item);
         end else begin
            want = pending_paints.pop_front();
            if (want.red !== rsp_item.red || want.green !== rsp_item.green ||
                want.blue !== rsp_item.blue || want.brightness !== rsp_item.brightness ||
                want.hold_ms !== rsp_item.hold_ms || want.last !== rsp_item.last)
               report_mismatch("paint differs", want, rsp_item);
         end
         paints_checked++;
      end
   end

   // Stall the result side at random, except during the calm phase
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Watchdog: give up after too many cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no transfer for %0d cycles, %0d paints still owed",
                  quiet_cycles, pending_paints.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one event, hold it until the transfer, then predict its paints.
   // Valid stays high afterwards; the next call or an idle cycle drops it.
   task automatic send_event(input logic [1:0] op, input logic [3:0] mode,
                             input logic [31:0] now, input logic so);
      req_type ev;
      ev.operation  = op;
      ev.mode       = mode;
      ev.now_ms     = now;
      ev.screen_off = so;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= ev;
      do @(posedge clock); while (req_stall);
      last_event_paints = predict_event(ev);
      events_sent++;
      if (last_event_paints > 0) events_painted++;
   endtask

   // Drop valid, wait until every owed paint is in, then let the pipeline settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_paints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while the block is idle; give the rescale time to land
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LED_ENABLE) cfg_led_enable = value[0];
      else cfg_percent = value;
      csr_writes++;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly held sessions with advancing time, some noise.
   // Runs until the given number of events have produced paints.
   task automatic run_random(input int target);
      int          produced;
      int          pick;
      logic [1:0]  op;
      logic [3:0]  mode;
      logic [31:0] stamp;
      logic        so;
      produced = 0;
      while (produced < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) ms_cursor = ms_cursor + $urandom_range(0, 300);
         else if (pick < 88) ms_cursor = ms_cursor + $urandom_range(150, 900);
         else if (pick < 94) ms_cursor = ms_cursor + $urandom;   // big jump, may wrap
         stamp = ms_cursor;
         if ($urandom_range(0, 99) < 5) stamp = $urandom;       // out-of-order timestamp
         mode = 4'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (!mdl_held)
            op = (pick < 75) ? OP_BEGIN : (pick < 88) ? OP_TICK :
                 (pick < 95) ? OP_SET_MODE : OP_END;
         else
            op = (pick < 48) ? OP_TICK : (pick < 88) ? OP_SET_MODE :
                 (pick < 95) ? OP_END : OP_BEGIN;
         if (op == OP_SET_MODE && $urandom_range(0, 99) < 85) mode = 4'($urandom_range(0, 8));
         so = ($urandom_range(0, 99) < 12);
         send_event(op, mode, stamp, so);
         if (last_event_paints > 0) produced++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Held flag, every steady and blinking mode, screen-off and undefined modes
   task automatic test_event_modes();
      send_event(OP_TICK, MODE_OFF, 32'd0, 1'b0);            // not held: no paint
      send_event(OP_BEGIN, MODE_OFF, 32'd100, 1'b0);
      send_event(OP_SET_MODE, MODE_CONNECTING, 32'd1000, 1'b0);
      send_event(OP_TICK, MODE_OFF, 32'd1700, 1'b0);         // half-period reached
      send_event(OP_SET_MODE, MODE_PAIRING, 32'd2000, 1'b0);
      send_event(OP_TICK, MODE_OFF, 32'd2280, 1'b0);
      send_event(OP_SET_MODE, MODE_HANDSHAKE, 32'd3000, 1'b0);
      send_event(OP_TICK, MODE_OFF, 32'd3179, 1'b0);         // one short of toggling
      send_event(OP_TICK, MODE_OFF, 32'd3180, 1'b1);         // screen off: dark, no toggle
      send_event(OP_SET_MODE, MODE_CONNECTED, 32'd4000, 1'b0);
      send_event(OP_SET_MODE, MODE_DISCONNECTED, 32'd4100, 1'b0);
      send_event(OP_SET_MODE, MODE_OFF, 32'd4200, 1'b0);
      send_event(OP_SET_MODE, 4'd9, 32'd4300, 1'b0);         // undefined mode values
      send_event(OP_SET_MODE, 4'd15, 32'd4400, 1'b0);
   endtask

   // Flash revert, error sequence, deadline wrapping to zero, time extremes
   task automatic test_flash_and_error();
      send_event(OP_SET_MODE, MODE_PAIRING, 32'd5000, 1'b0);
      send_event(OP_SET_MODE, MODE_REJECT, 32'd5100, 1'b0);  // returns to pairing
      send_event(OP_TICK, MODE_OFF, 32'd5280, 1'b0);         // flash expires exactly
      send_event(OP_SET_MODE, MODE_FORGET_OK, 32'd6000, 1'b0);
      send_event(OP_TICK, MODE_OFF, 32'd6220, 1'b0);         // back to off
      send_event(OP_SET_MODE, MODE_ERROR, 32'd7000, 1'b0);
      send_event(OP_SET_MODE, MODE_REJECT, 32'hFFFF_FF4C, 1'b0); // deadline wraps to 0
      send_event(OP_TICK, MODE_OFF, 32'hFFFF_FFFF, 1'b0);    // so the flash never ends
      send_event(OP_SET_MODE, MODE_ERROR, 32'd0, 1'b1);      // error with screen off
      send_event(OP_END, MODE_ERROR, 32'hFFFF_FFFF, 1'b0);
      send_event(OP_TICK, MODE_CONNECTED, 32'd7500, 1'b0);   // released: no paint
   endtask

   // Sweep both registers (brightness from 0 to 100 percent), random traffic under each
   task automatic test_register_sweep();
      logic       sweep_enable[7] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
      logic [6:0] sweep_percent[7] = '{7'd100, 7'd100, 7'd0, 7'd3, 7'd1, 7'd50, 7'd100};
      for (int s = 0; s < 7; s++) begin
         write_csr(CSR_LED_ENABLE, {6'd0, sweep_enable[s]});
         write_csr(CSR_BRIGHTNESS, sweep_percent[s]);
         calm = (s == 0);   // one long stretch with no idling on either side
         run_random(PHASE_EVENTS);
         calm = 1'b0;
      end
   endtask

   initial begin
      // Predictor reset state
      cfg_led_enable  = 1'b1;
      cfg_percent     = 7'd100;
      mdl_mode        = MODE_OFF;
      mdl_after_flash = MODE_CONNECTING;
      mdl_deadline    = 32'd0;
      mdl_phase_on    = 1'b0;
      mdl_toggle_ms   = 32'd0;
      mdl_held        = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_event_modes();
      test_flash_and_error();
      test_register_sweep();

      wait_for_idle();
      $display("Covered %0d events (%0d painting) and %0d register writes; %0d paints checked",
               events_sent, events_painted, csr_writes, paints_checked);
      $display("%0d mismatches, %0d paints left owed", mismatch_count, pending_paints.size());
      if (mismatch_count == 0 && pending_paints.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/slbc_pkg.sv
rtl/core/slbc_step.sv
rtl/core/status_led_blink_controller.sv
rtl/core/slbc_checker.sv
tb/status_led_blink_controller_tb.sv
